/* rtl/core/sfs_pkg.sv */
`timescale 1ns / 1ps

package sfs_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PING_PONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE = 2'd2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  frame_slot;
        logic [15:0] load_x;
        logic [15:0] load_y;
        logic [15:0] load_w;
        logic [15:0] load_h;
        logic [15:0] load_duration;
    } t_in_item;

    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [5:0]  shown_frame;
        logic        frame_changed;
        logic        finished;
        logic        running;
    } t_out_item;

    // fresh: ticks not yet loaded, the count is the stored duration of index
    typedef struct packed {
        logic [5:0]  index;
        logic        backward;
        logic [15:0] ticks;
        logic        fresh;
        logic        active;
    } t_chan_state;

    typedef struct packed {
        logic changed;
        logic finished;
    } t_step_flags;

endpackage

/* rtl/core/sprite_frame_sequencer.sv */
`timescale 1ns / 1ps
// One sprite animation channel.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries load, start and
// tick transactions; every accepted transaction yields exactly one result on
// the output channel (o_out_valid / i_out_stall / o_out_data) describing the
// frame shown after it, in order.
// Configuration (frame_count, ping_pong, repeat_mode) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while the
// channel is idle; the block does not enforce this. Results are registered.
// Throughput: one transaction per cycle while the output is not stalled;
// each store has one registered read port, durations read at the next frame
// index every cycle and rects when a transaction fires.
// Reset: synchronous; i_rst_n low returns to frame 0, forward, idle, with
// frame_count 1 and both modes clear. Frame store contents are undefined
// until loaded.
// A stalled result holds; one more transaction is held in the input register
// and then o_in_stall rises until the output drains.

module sprite_frame_sequencer #(
    parameter int unsigned MAX_FRAMES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sfs_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sfs_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_FRAMES);

    logic [63:0] rect_mem [MAX_FRAMES];
    logic [15:0] dur_mem  [MAX_FRAMES];

    logic                 r_in_valid;
    sfs_pkg::t_in_item    r_in;
    sfs_pkg::t_chan_state r_state;
    sfs_pkg::t_chan_state step_state;
    sfs_pkg::t_chan_state n_state;
    sfs_pkg::t_step_flags step_flags;
    logic [6:0]           r_frame_count;
    logic                 r_ping_pong;
    logic                 r_repeat_mode;
    logic [15:0]          r_dur;
    logic                 r_dur_ok;
    logic [63:0]          r_rect;
    logic                 r_rect_ok;
    logic                 r_out_valid;
    logic [5:0]           r_shown;
    sfs_pkg::t_step_flags r_flags;
    logic                 r_running;

    logic          fire;
    logic          in_accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_rect;
    logic [AW-1:0] rd_addr;
    logic          rd_ok;
    logic [15:0]   dur_eff;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign wr_en   = fire && r_in.op == sfs_pkg::OP_LOAD
                     && 32'(r_in.frame_slot) < 32'(MAX_FRAMES);
    assign wr_addr = AW'(r_in.frame_slot);
    assign wr_rect = {r_in.load_h, r_in.load_w, r_in.load_y, r_in.load_x};
    assign dur_eff = r_dur_ok ? r_dur : 16'd0;

    sfs_step #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_step (
        .i_op          (r_in.op),
        .i_slot        (r_in.frame_slot),
        .i_state       (r_state),
        .i_dur         (dur_eff),
        .i_frame_count (r_frame_count),
        .i_ping_pong   (r_ping_pong),
        .i_repeat_mode (r_repeat_mode),
        .o_state       (step_state),
        .o_flags       (step_flags)
    );

    assign n_state = fire ? step_state : r_state;
    assign rd_addr = AW'(n_state.index);
    assign rd_ok   = 32'(n_state.index) < 32'(MAX_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_frame_count <= 7'd1;
            r_ping_pong   <= 1'b0;
            r_repeat_mode <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sfs_pkg::REG_FRAME_COUNT: r_frame_count <= i_cfg_data;
                    sfs_pkg::REG_PING_PONG:   r_ping_pong   <= i_cfg_data[0];
                    sfs_pkg::REG_REPEAT_MODE: r_repeat_mode <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_shown   <= step_state.index;
            r_flags   <= step_flags;
            r_running <= step_state.active;
        end
    end

    // frame stores, read-during-write returns the new data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            rect_mem[wr_addr] <= wr_rect;
            dur_mem[wr_addr]  <= r_in.load_duration;
        end
        if (wr_en && wr_addr == rd_addr) begin
            r_dur <= r_in.load_duration;
        end else begin
            r_dur <= dur_mem[rd_addr];
        end
        r_dur_ok <= rd_ok;
        if (fire) begin
            if (wr_en && wr_addr == rd_addr) begin
                r_rect <= wr_rect;
            end else begin
                r_rect <= rect_mem[rd_addr];
            end
            r_rect_ok <= rd_ok;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_out_data.rect_x        = r_rect_ok ? r_rect[15:0]  : 16'd0;
    assign o_out_data.rect_y        = r_rect_ok ? r_rect[31:16] : 16'd0;
    assign o_out_data.rect_w        = r_rect_ok ? r_rect[47:32] : 16'd0;
    assign o_out_data.rect_h        = r_rect_ok ? r_rect[63:48] : 16'd0;
    assign o_out_data.shown_frame   = r_shown;
    assign o_out_data.frame_changed = r_flags.changed;
    assign o_out_data.finished      = r_flags.finished;
    assign o_out_data.running       = r_running;

endmodule

/* rtl/core/sfs_step.sv */
`timescale 1ns / 1ps

module sfs_step #(
    parameter int unsigned MAX_FRAMES = 64
) (
    input  logic [1:0]          i_op,
    input  logic [5:0]          i_slot,
    input  sfs_pkg::t_chan_state i_state,
    input  logic [15:0]         i_dur,
    input  logic [6:0]          i_frame_count,
    input  logic                i_ping_pong,
    input  logic                i_repeat_mode,
    output sfs_pkg::t_chan_state o_state,
    output sfs_pkg::t_step_flags o_flags
);

    localparam int unsigned MaxLen = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;

    logic [6:0]  strip_len;
    logic [6:0]  last;
    logic        at_end;
    logic [15:0] ticks_now;
    logic [5:0]  adv_idx;
    logic        adv_back;
    logic        adv_fin;

    always_comb begin
        if (i_frame_count == 7'd0) begin
            strip_len = 7'd1;
        end else if (i_frame_count > 7'(MaxLen)) begin
            strip_len = 7'(MaxLen);
        end else begin
            strip_len = i_frame_count;
        end
        last      = strip_len - 7'd1;
        at_end    = {1'b0, i_state.index} >= last;
        ticks_now = i_state.fresh ? i_dur : i_state.ticks;
    end

    always_comb begin
        adv_idx  = i_state.index;
        adv_back = i_state.backward;
        adv_fin  = 1'b0;
        if (at_end) begin
            if (i_ping_pong) begin
                if (last == 7'd0) begin
                    adv_back = 1'b0;
                    adv_fin  = !i_repeat_mode;
                    adv_idx  = 6'd0;
                end else begin
                    adv_back = 1'b1;
                    adv_idx  = 6'(last - 7'd1);
                end
            end else if (i_repeat_mode) begin
                adv_idx = 6'd0;
            end else begin
                adv_fin = 1'b1;
            end
        end else if (i_state.index == 6'd0) begin
            if (i_state.backward) begin
                adv_back = 1'b0;
                adv_fin  = i_ping_pong && !i_repeat_mode;
            end
            adv_idx = 6'd1;
        end else begin
            adv_idx = i_state.backward ? i_state.index - 6'd1 : i_state.index + 6'd1;
        end
    end

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        unique case (i_op)
            sfs_pkg::OP_LOAD: begin
                // pin the count before the store entry it depends on changes
                if (i_state.fresh && i_slot == i_state.index) begin
                    o_state.ticks = i_dur;
                    o_state.fresh = 1'b0;
                end
            end
            sfs_pkg::OP_START: begin
                o_state.index    = 6'd0;
                o_state.backward = 1'b0;
                o_state.fresh    = 1'b1;
                o_state.active   = 1'b1;
                o_flags.changed  = 1'b1;
            end
            sfs_pkg::OP_TICK: begin
                if (i_state.active) begin
                    if (ticks_now <= 16'd1) begin
                        o_state.backward = adv_back;
                        if (adv_fin) begin
                            o_state.ticks    = 16'd0;
                            o_state.fresh    = 1'b0;
                            o_state.active   = 1'b0;
                            o_flags.finished = 1'b1;
                        end else begin
                            o_state.index   = adv_idx;
                            o_state.fresh   = 1'b1;
                            o_flags.changed = 1'b1;
                        end
                    end else begin
                        o_state.ticks = ticks_now - 16'd1;
                        o_state.fresh = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/core/sfs_checker.sv */
`timescale 1ns / 1ps

module sfs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input sfs_pkg::t_in_item               i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input sfs_pkg::t_out_item              o_out_data,
    input logic                            i_cfg_we,
    input logic [sfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output side free");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.finished)
            |-> (!o_out_data.running && !o_out_data.frame_changed))
        else $error("finished result still running or changed");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.op == sfs_pkg::OP_START
            && !o_out_valid && !o_in_stall && !i_out_stall && !i_cfg_we)
            |=> ##1 (!o_out_valid || o_out_data.running || o_out_data.finished
                     || o_out_data.shown_frame == 6'd0 || !o_out_data.frame_changed))
        else $error("start result malformed");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);

/* sim/tb_sprite_frame_sequencer.sv */
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    sfs_pkg::t_in_item              i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    sfs_pkg::t_out_item             o_out_data;
    logic                           i_cfg_we = 1'b0;
    logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    sprite_frame_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // channel state mirror
    logic [15:0] rect_x_mem [64];
    logic [15:0] rect_y_mem [64];
    logic [15:0] rect_w_mem [64];
    logic [15:0] rect_h_mem [64];
    logic [15:0] dwell_mem  [64];
    logic [5:0]  shown_idx = '0;
    logic        reversing = 1'b0;
    int unsigned dwell_left = 0;
    logic        playing = 1'b0;
    logic [6:0]  strip_frames = 7'd1;
    logic        bounce = 1'b0;
    logic        looping = 1'b0;

    sfs_pkg::t_out_item pending_frames [$];
    int                 mismatch_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    // returns 1 when the strip ends
    function automatic bit advance_strip();
        logic [6:0] n;
        logic [6:0] end_idx;
        logic [6:0] idx;
        n = strip_frames;
        if (n == 0) n = 7'd1;
        if (n > 64) n = 7'd64;
        end_idx = n - 7'd1;
        idx = {1'b0, shown_idx};
        if (idx >= end_idx) begin
            if (bounce) begin
                if (end_idx == 0) begin
                    reversing = 1'b0;
                    if (!looping) return 1'b1;
                    idx = '0;
                end else begin
                    reversing = 1'b1;
                    idx = end_idx - 7'd1;
                end
            end else if (looping) begin
                idx = '0;
            end else begin
                return 1'b1;
            end
        end else if (idx == 0) begin
            if (reversing) begin
                reversing = 1'b0;
                if (bounce && !looping) return 1'b1;
            end
            idx = 7'd1;
        end else begin
            idx = reversing ? idx - 7'd1 : idx + 7'd1;
        end
        shown_idx = idx[5:0];
        dwell_left = dwell_mem[shown_idx];
        return 1'b0;
    endfunction

    task automatic apply_transaction(input sfs_pkg::t_in_item item,
                                     output sfs_pkg::t_out_item r);
        r = '0;
        case (item.op)
            sfs_pkg::OP_LOAD: begin
                rect_x_mem[item.frame_slot] = item.load_x;
                rect_y_mem[item.frame_slot] = item.load_y;
                rect_w_mem[item.frame_slot] = item.load_w;
                rect_h_mem[item.frame_slot] = item.load_h;
                dwell_mem[item.frame_slot]  = item.load_duration;
            end
            sfs_pkg::OP_START: begin
                shown_idx = '0;
                reversing = 1'b0;
                dwell_left = dwell_mem[0];
                playing = 1'b1;
                r.frame_changed = 1'b1;
            end
            sfs_pkg::OP_TICK: begin
                if (playing) begin
                    if (dwell_left <= 1) begin
                        dwell_left = 0;
                        if (advance_strip()) begin
                            playing = 1'b0;
                            r.finished = 1'b1;
                        end else begin
                            r.frame_changed = 1'b1;
                        end
                    end else begin
                        dwell_left = dwell_left - 1;
                    end
                end
            end
            default: ;
        endcase
        r.rect_x = rect_x_mem[shown_idx];
        r.rect_y = rect_y_mem[shown_idx];
        r.rect_w = rect_w_mem[shown_idx];
        r.rect_h = rect_h_mem[shown_idx];
        r.shown_frame = shown_idx;
        r.running = playing;
    endtask

    task automatic push_item(input sfs_pkg::t_in_item item);
        sfs_pkg::t_out_item want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_transaction(item, want);
        pending_frames.push_back(want);
    endtask

    task automatic load_frame(input logic [5:0] slot, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] w,
                              input logic [15:0] h, input logic [15:0] dwell);
        sfs_pkg::t_in_item item;
        item = '{sfs_pkg::OP_LOAD, slot, x, y, w, h, dwell};
        push_item(item);
    endtask

    // non-load ops carry random filler in the load fields
    task automatic send_op(input logic [1:0] op);
        sfs_pkg::t_in_item item;
        item = '{op, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom)};
        push_item(item);
    endtask

    task automatic settle_channel();
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfs_pkg::CFG_DATA_W-1:0] data);
        settle_channel();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sfs_pkg::REG_FRAME_COUNT: strip_frames = data;
            sfs_pkg::REG_PING_PONG:   bounce = data[0];
            sfs_pkg::REG_REPEAT_MODE: looping = data[0];
            default: ;
        endcase
    endtask

    task automatic set_strip(input logic [6:0] n, input logic pp, input logic rep);
        write_reg(sfs_pkg::REG_FRAME_COUNT, n);
        write_reg(sfs_pkg::REG_PING_PONG, {6'd0, pp});
        write_reg(sfs_pkg::REG_REPEAT_MODE, {6'd0, rep});
    endtask

    // every slot written up front so no read ever hits an unwritten entry
    task automatic test_preload_store();
        for (int s = 0; s < 64; s++) begin
            if (s == 0)
                load_frame(6'(s), 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
            else if (s == 63)
                load_frame(6'(s), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
            else if (s < 4)
                load_frame(6'(s), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'd1);
            else
                load_frame(6'(s), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom_range(3)));
        end
    endtask

    task automatic test_forward_once();
        set_strip(7'd3, 1'b0, 1'b0);
        send_op(sfs_pkg::OP_START);
        repeat (4) send_op(sfs_pkg::OP_TICK);
        send_op(sfs_pkg::OP_NONE);
    endtask

    task automatic test_long_dwell();
        load_frame(6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_op(sfs_pkg::OP_START);
        repeat (2) send_op(sfs_pkg::OP_TICK);
        load_frame(6'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
        send_op(sfs_pkg::OP_START);
    endtask

    task automatic test_ping_pong_once();
        set_strip(7'd3, 1'b1, 1'b0);
        send_op(sfs_pkg::OP_START);
        repeat (5) send_op(sfs_pkg::OP_TICK);
    endtask

    task automatic test_single_frame_bounce();
        set_strip(7'd1, 1'b1, 1'b1);
        send_op(sfs_pkg::OP_START);
        repeat (2) send_op(sfs_pkg::OP_TICK);
        write_reg(sfs_pkg::REG_REPEAT_MODE, '0);
        send_op(sfs_pkg::OP_TICK);
    endtask

    task automatic test_random_strips(input int rounds);
        logic [6:0] n;
        int pick;
        for (int r = 0; r < rounds; r++) begin
            case ($urandom_range(7))
                0: n = 7'd0;
                1: n = 7'd1;
                2: n = 7'd64;
                3: n = 7'd127;
                4: n = 7'($urandom_range(126, 65));
                default: n = 7'($urandom_range(8, 2));
            endcase
            if ($urandom_range(9) < 7) write_reg(sfs_pkg::REG_FRAME_COUNT, n);
            if ($urandom_range(9) < 6)
                write_reg(sfs_pkg::REG_PING_PONG, {6'd0, 1'($urandom)});
            if ($urandom_range(9) < 6)
                write_reg(sfs_pkg::REG_REPEAT_MODE, {6'd0, 1'($urandom)});
            if ($urandom_range(9) < 3) send_op(sfs_pkg::OP_START);
            for (int k = 0; k < 25; k++) begin
                pick = $urandom_range(99);
                if (pick < 72)
                    send_op(sfs_pkg::OP_TICK);
                else if (pick < 82)
                    send_op(sfs_pkg::OP_START);
                else if (pick < 96)
                    load_frame(6'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom),
                               ($urandom_range(9) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(4)));
                else
                    send_op(sfs_pkg::OP_NONE);
            end
        end
    endtask

    always @(posedge i_clk) begin
        sfs_pkg::t_out_item want;
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: got %p", o_out_data);
            end else begin
                want = pending_frames.pop_front();
                if (o_out_data.rect_x !== want.rect_x ||
                    o_out_data.rect_y !== want.rect_y ||
                    o_out_data.rect_w !== want.rect_w ||
                    o_out_data.rect_h !== want.rect_h ||
                    o_out_data.shown_frame !== want.shown_frame ||
                    o_out_data.frame_changed !== want.frame_changed ||
                    o_out_data.finished !== want.finished ||
                    o_out_data.running !== want.running) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p got %p", want, o_out_data);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_sprite_frame_sequencer: errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_stall_pct = 66;
        test_preload_store();
        test_forward_once();
        test_long_dwell();
        test_ping_pong_once();
        test_single_frame_bounce();
        test_random_strips(9);

        send_idle_pct = 66;
        recv_stall_pct = 31;
        test_random_strips(9);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_strips(8);

        settle_channel();
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_sprite_frame_sequencer: clean");
        else
            $display("tb_sprite_frame_sequencer: errors");
        $finish;
    end

endmodule
